/* rtl/core/rtlc_pkg.sv */
`timescale 1ns / 1ps

package rtlc_pkg;

	localparam int TICKS_PER_SECOND = 1000;
	localparam int COUNT_BITS       = 22;
	localparam int SECONDS_W        = 12;
	localparam int CFG_DATA_W       = SECONDS_W;
	localparam int CFG_INDEX_W      = 3;
	localparam int MODE_W           = 3;

	// product width of seconds times ticks, and a width that holds it and the count limit
	localparam int TPS_W  = $clog2(TICKS_PER_SECOND + 1);
	localparam int PROD_W = SECONDS_W + TPS_W;
	localparam int WIDE_W = (PROD_W > COUNT_BITS) ? PROD_W : COUNT_BITS;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	typedef logic [COUNT_BITS-1:0] count_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_TICK        = 3'd0,
		MODE_TOGGLE      = 3'd1,
		MODE_FORCE_GREEN = 3'd2,
		MODE_FORCE_RED   = 3'd3,
		MODE_RESTART     = 3'd4
	} mode_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_AUTO_ENABLE    = 3'd0,
		REG_TOGGLE_ENABLE  = 3'd1,
		REG_REQUEST_ENABLE = 3'd2,
		REG_RED_SECONDS    = 3'd3,
		REG_GREEN_SECONDS  = 3'd4,
		REG_DELAY_SECONDS  = 3'd5
	} cfg_index_t;

	// settings, with timer lengths already in ticks
	typedef struct packed {
		logic   auto_en;
		logic   toggle_en;
		logic   req_en;
		count_t red_ticks;
		count_t green_ticks;
		count_t delay_ticks;
	} cfg_t;

	typedef struct packed {
		logic   green;
		logic   last_btn;
		logic   ph_armed;
		count_t ph_left;
		logic   rq_armed;
		count_t rq_left;
	} state_t;

	function automatic count_t to_ticks(logic [SECONDS_W-1:0] secs);
		logic [WIDE_W-1:0] prod;
		prod = WIDE_W'(secs) * WIDE_W'(TICKS_PER_SECOND);
		if (prod > WIDE_W'(COUNT_MAX)) begin
			return COUNT_MAX;
		end
		return COUNT_BITS'(prod);
	endfunction

	// phase timer expiry: green goes red, red goes green only in auto mode
	function automatic state_t phase_event(state_t s, cfg_t c);
		state_t r;
		r          = s;
		r.ph_armed = 1'b0;
		r.ph_left  = '0;
		if (s.green) begin
			r.green    = 1'b0;
			r.ph_armed = 1'b1;
			r.ph_left  = c.red_ticks;
		end else if (c.auto_en) begin
			r.green    = 1'b1;
			r.ph_armed = 1'b1;
			r.ph_left  = c.green_ticks;
		end
		return r;
	endfunction

endpackage

/* rtl/core/rtlc_cfg.sv */
`timescale 1ns / 1ps

module rtlc_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [rtlc_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [rtlc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	output rtlc_pkg::cfg_t                     cfg
);

	rtlc_pkg::cfg_t   cfg_q;
	rtlc_pkg::count_t wr_ticks;

	// one multiplier shared by the three timer registers
	assign wr_ticks = rtlc_pkg::to_ticks(cfg_wdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.auto_en     <= 1'b0;
			cfg_q.toggle_en   <= 1'b0;
			cfg_q.req_en      <= 1'b0;
			cfg_q.red_ticks   <= rtlc_pkg::to_ticks(rtlc_pkg::SECONDS_W'(30));
			cfg_q.green_ticks <= rtlc_pkg::to_ticks(rtlc_pkg::SECONDS_W'(30));
			cfg_q.delay_ticks <= rtlc_pkg::to_ticks(rtlc_pkg::SECONDS_W'(5));
		end else if (cfg_we) begin
			unique case (cfg_index)
				rtlc_pkg::REG_AUTO_ENABLE:    cfg_q.auto_en     <= cfg_wdata[0];
				rtlc_pkg::REG_TOGGLE_ENABLE:  cfg_q.toggle_en   <= cfg_wdata[0];
				rtlc_pkg::REG_REQUEST_ENABLE: cfg_q.req_en      <= cfg_wdata[0];
				rtlc_pkg::REG_RED_SECONDS:    cfg_q.red_ticks   <= wr_ticks;
				rtlc_pkg::REG_GREEN_SECONDS:  cfg_q.green_ticks <= wr_ticks;
				rtlc_pkg::REG_DELAY_SECONDS:  cfg_q.delay_ticks <= wr_ticks;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* rtl/core/rtlc_step.sv */
`timescale 1ns / 1ps

module rtlc_step (
	input  rtlc_pkg::state_t              cur,
	input  rtlc_pkg::cfg_t                cfg,
	input  logic [rtlc_pkg::MODE_W-1:0]   mode,
	input  logic                          level,
	output rtlc_pkg::state_t              nxt,
	output logic                          lamp_set
);

	rtlc_pkg::state_t s;
	logic             drv;

	always_comb begin
		s   = cur;
		drv = 1'b0;
		unique case (mode)
			rtlc_pkg::MODE_TICK: begin
				if (s.ph_left != '0) s.ph_left = s.ph_left - rtlc_pkg::COUNT_BITS'(1);
				if (s.rq_left != '0) s.rq_left = s.rq_left - rtlc_pkg::COUNT_BITS'(1);
				if (level != s.last_btn) begin
					s.last_btn = level;
					if (level) begin
						if (cfg.toggle_en) begin
							drv = 1'b1;
							if (cfg.auto_en) s = rtlc_pkg::phase_event(s, cfg);
							else s.green = !s.green;
						end
						// request is judged on the light after any toggle
						if (cfg.req_en && !s.green) begin
							s.rq_armed = 1'b1;
							s.rq_left  = cfg.delay_ticks;
						end
					end
				end
				// phase timer is handled before the request timer; a request timer firing in the same pass overrides it
				if (s.ph_armed && s.ph_left == '0) begin
					drv = drv | s.green | cfg.auto_en;
					s   = rtlc_pkg::phase_event(s, cfg);
				end
				if (s.rq_armed && s.rq_left == '0) begin
					s.rq_armed = 1'b0;
					s.green    = 1'b1;
					drv        = 1'b1;
					s.ph_armed = 1'b1;
					s.ph_left  = cfg.green_ticks;
				end
			end
			rtlc_pkg::MODE_TOGGLE: begin
				if (cfg.auto_en) begin
					// in auto mode the phase step always drives a lamp
					drv = 1'b1;
					s   = rtlc_pkg::phase_event(s, cfg);
				end else if (s.green) begin
					s.green = 1'b0;
					drv     = 1'b1;
				end else begin
					s.rq_armed = 1'b0;
					s.rq_left  = '0;
					s.green    = 1'b1;
					drv        = 1'b1;
					if (cfg.req_en) begin
						s.ph_armed = 1'b1;
						s.ph_left  = cfg.green_ticks;
					end
				end
			end
			rtlc_pkg::MODE_FORCE_GREEN: begin
				s.rq_armed = 1'b0;
				s.rq_left  = '0;
				drv        = 1'b1;
				if (cfg.auto_en) begin
					s.green = 1'b0;
					s       = rtlc_pkg::phase_event(s, cfg);
				end else begin
					s.green = 1'b1;
				end
			end
			rtlc_pkg::MODE_FORCE_RED: begin
				drv = 1'b1;
				if (cfg.auto_en) begin
					s.green = 1'b1;
					s       = rtlc_pkg::phase_event(s, cfg);
				end else begin
					s.green = 1'b0;
				end
			end
			rtlc_pkg::MODE_RESTART: begin
				drv        = 1'b1;
				s.green    = 1'b0;
				s.rq_armed = 1'b0;
				s.rq_left  = '0;
				s.ph_armed = cfg.auto_en;
				s.ph_left  = cfg.auto_en ? cfg.red_ticks : '0;
			end
			default: ;
		endcase
	end

	assign nxt      = s;
	assign lamp_set = drv;

endmodule

/* rtl/core/request_traffic_light_controller_core.sv */
`timescale 1ns / 1ps
// Pedestrian-request red/green light controller.
// A request taken is held in the input stage, then its result is registered in the result stage.
// Throughput: one request per cycle while results are taken; a held result stalls the input stage.
// Reset (arst_n low, asynchronous): both stages empty, light red, timers stopped,
// settings back to defaults (all modes off, red 30 s, green 30 s, delay 5 s).

module request_traffic_light_controller_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [rtlc_pkg::MODE_W-1:0]        mode,
	input  logic                               button_a,
	input  logic                               button_b,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               green_on,
	output logic                               lamp_set,
	output logic                               request_pending,
	input  logic                               cfg_we,
	input  logic [rtlc_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [rtlc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

	rtlc_pkg::cfg_t   cfg;
	rtlc_pkg::state_t state_q;
	rtlc_pkg::state_t state_nxt;
	logic             lamp_nxt;

	// input stage
	logic                          valid_s1;
	logic [rtlc_pkg::MODE_W-1:0]   mode_s1;
	logic                          level_s1;

	// result stage
	logic out_valid_q;
	logic green_s2;
	logic lamp_s2;
	logic pending_s2;

	logic advance;

	rtlc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// one pass of the controller for the request held in the input stage
	rtlc_step u_step (
		.cur      (state_q),
		.cfg      (cfg),
		.mode     (mode_s1),
		.level    (level_s1),
		.nxt      (state_nxt),
		.lamp_set (lamp_nxt)
	);

	// the input stage moves on whenever the result slot is free or being drained
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_s1  <= mode;
			level_s1 <= button_a | button_b;
		end
	end

	// controller state only changes as a request passes to the result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			green_s2   <= state_nxt.green;
			lamp_s2    <= lamp_nxt;
			pending_s2 <= state_nxt.rq_armed;
		end
	end

	assign out_valid       = out_valid_q;
	assign green_on        = green_s2;
	assign lamp_set        = lamp_s2;
	assign request_pending = pending_s2;

endmodule

/* rtl/core/rtlc_checker.sv */
`timescale 1ns / 1ps

module rtlc_checker (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic green_on,
	input logic lamp_set,
	input logic request_pending
);

	// a held result keeps its value until taken
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(green_on) && $stable(lamp_set)
			&& $stable(request_pending))
		else $error("result changed while stalled");

	// the block only refuses a request when a result is held back
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output backpressure");

	// no result while in reset
	assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result shown during reset");

	// with no result held the input side is always open
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

endmodule

bind request_traffic_light_controller_core rtlc_checker u_rtlc_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_ready        (in_ready),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.green_on        (green_on),
	.lamp_set        (lamp_set),
	.request_pending (request_pending)
);

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;
	import rtlc_pkg::*;

	localparam int HALF_PERIOD    = 5;
	localparam int RESET_CYCLES   = 12;
	localparam int MAX_WAIT       = 16;   // longest random gap or stall, in cycles
	localparam int HOLD_CYCLES    = 300;  // long receiver hold-off
	localparam int SETTLE_CYCLES  = 4;    // two-stage pipe, plus margin
	localparam int WATCHDOG_LIMIT = 2000; // cycles with no handshake at all
	localparam int LONG_TICKS     = 1003; // one full 1 s phase plus the flip back

	// modes the block must ignore
	localparam logic [MODE_W-1:0] MODE_UNUSED_FIRST = 3'd5;
	localparam logic [MODE_W-1:0] MODE_UNUSED_LAST  = 3'd7;

	// ---------------------------------------------------------------
	// DUT ports; every input starts at a known value
	// ---------------------------------------------------------------
	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   in_valid  = 1'b0;
	logic                   in_ready;
	logic [MODE_W-1:0]      mode      = '0;
	logic                   button_a  = 1'b0;
	logic                   button_b  = 1'b0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic                   green_on;
	logic                   lamp_set;
	logic                   request_pending;
	logic                   cfg_we    = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

	request_traffic_light_controller_core i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.mode            (mode),
		.button_a        (button_a),
		.button_b        (button_b),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.green_on        (green_on),
		.lamp_set        (lamp_set),
		.request_pending (request_pending),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata)
	);

	always #HALF_PERIOD clk = ~clk;

	// one request on the input channel; gap = idle cycles after it is taken
	typedef struct {
		logic [MODE_W-1:0] mode;
		logic              btn_a;
		logic              btn_b;
		int                gap;
	} light_req_t;

	// one result as the output channel shows it
	typedef struct packed {
		logic green;
		logic lamp;
		logic pend;
	} lamp_state_t;

	light_req_t  request_q[$];     // requests not yet on the port
	light_req_t  on_port;          // request currently offered
	lamp_state_t lamp_expect_q[$]; // predicted results, oldest first
	lamp_state_t rx_want;

	int   tx_idle_left   = 0;
	int   rx_stall_left  = 0;
	int   sent_total     = 0;
	int   checked_total  = 0;
	int   mismatch_count = 0;
	int   idle_cycles    = 0;
	logic no_idle        = 1'b0; // phases with back-to-back traffic on both sides
	logic rx_hold_start  = 1'b0; // asks the receiver for one long hold-off

	// ---------------------------------------------------------------
	// Light predictor: its own copy of settings and state
	// ---------------------------------------------------------------
	logic                 ctl_auto   = 1'b0;
	logic                 ctl_toggle = 1'b0;
	logic                 ctl_req    = 1'b0;
	logic [SECONDS_W-1:0] ctl_red    = 12'd30;
	logic [SECONDS_W-1:0] ctl_green  = 12'd30;
	logic [SECONDS_W-1:0] ctl_delay  = 12'd5;

	logic   lt_green    = 1'b0;
	logic   lt_last_btn = 1'b0;
	logic   lt_ph_armed = 1'b0;
	count_t lt_ph_left  = '0;
	logic   lt_rq_armed = 1'b0;
	count_t lt_rq_left  = '0;
	logic   lt_driven   = 1'b0;

	// seconds to ticks, clipped to the counter range
	function automatic count_t secs_to_count(logic [SECONDS_W-1:0] secs);
		logic [63:0] t;
		t = 64'(secs) * 64'(TICKS_PER_SECOND);
		if (t > 64'(COUNT_MAX)) return COUNT_MAX;
		return count_t'(t);
	endfunction

	function automatic void arm_phase_timer(logic [SECONDS_W-1:0] secs);
		lt_ph_armed = 1'b1;
		lt_ph_left  = secs_to_count(secs);
	endfunction

	function automatic void drive_lamp(logic g);
		lt_green  = g;
		lt_driven = 1'b1;
	endfunction

	// phase timer ran out: green always goes red, red goes green only in auto
	function automatic void phase_expire();
		lt_ph_armed = 1'b0;
		lt_ph_left  = '0;
		if (lt_green) begin
			drive_lamp(1'b0);
			arm_phase_timer(ctl_red);
		end else if (ctl_auto) begin
			drive_lamp(1'b1);
			arm_phase_timer(ctl_green);
		end
	endfunction

	function automatic void cancel_request();
		lt_rq_armed = 1'b0;
		lt_rq_left  = '0;
	endfunction

	function automatic void force_green_cmd();
		cancel_request();
		if (ctl_auto) begin
			lt_green = 1'b0;
			phase_expire();
		end else begin
			drive_lamp(1'b1);
		end
	endfunction

	function automatic void force_red_cmd();
		if (ctl_auto) begin
			lt_green = 1'b1;
			phase_expire();
		end else begin
			drive_lamp(1'b0);
		end
	endfunction

	function automatic lamp_state_t predict_lamps(light_req_t r);
		logic        level;
		lamp_state_t res;
		level     = r.btn_a | r.btn_b;
		lt_driven = 1'b0;
		case (r.mode)
			MODE_TICK: begin
				// count down first, saturating at zero
				if (lt_ph_left != 0) lt_ph_left--;
				if (lt_rq_left != 0) lt_rq_left--;
				// rising edge of either button
				if (level != lt_last_btn) begin
					lt_last_btn = level;
					if (level) begin
						if (ctl_toggle) begin
							if (ctl_auto) phase_expire();
							else drive_lamp(!lt_green);
						end
						if (ctl_req && !lt_green) begin
							lt_rq_armed = 1'b1;
							lt_rq_left  = secs_to_count(ctl_delay);
						end
					end
				end
				// phase timer fires before the request timer
				if (lt_ph_armed && lt_ph_left == 0) phase_expire();
				if (lt_rq_armed && lt_rq_left == 0) begin
					lt_rq_armed = 1'b0;
					drive_lamp(1'b1);
					arm_phase_timer(ctl_green);
				end
			end
			MODE_TOGGLE: begin
				if (ctl_auto) begin
					phase_expire();
				end else if (lt_green) begin
					drive_lamp(1'b0);
				end else begin
					force_green_cmd();
					if (ctl_req) arm_phase_timer(ctl_green);
				end
			end
			MODE_FORCE_GREEN: force_green_cmd();
			MODE_FORCE_RED:   force_red_cmd();
			MODE_RESTART: begin
				lt_ph_armed = 1'b0;
				lt_ph_left  = '0;
				cancel_request();
				force_red_cmd();
				if (ctl_auto) arm_phase_timer(ctl_red);
			end
			default: ; // unused modes: nothing moves, nothing is driven
		endcase
		res.green = lt_green;
		res.lamp  = lt_driven;
		res.pend  = lt_rq_armed;
		return res;
	endfunction

	// per-request wait for either side; at least half the draws are zero
	function automatic int draw_wait();
		if (no_idle) return 0;
		return $urandom_range(0, 1) ? 0 : int'($urandom_range(0, MAX_WAIT));
	endfunction

	// ---------------------------------------------------------------
	// Driver: offers queued requests, predicts each one as it is taken
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid     <= 1'b0;
			mode         <= '0;
			button_a     <= 1'b0;
			button_b     <= 1'b0;
			tx_idle_left = 0;
		end else begin
			if (in_valid && in_ready) begin
				lamp_expect_q.push_back(predict_lamps(on_port));
			end
			// port is free after this edge unless a request is still waiting
			if (!in_valid || in_ready) begin
				if (tx_idle_left > 0) begin
					tx_idle_left--;
					in_valid <= 1'b0;
				end else if (request_q.size() != 0) begin
					on_port      = request_q.pop_front();
					tx_idle_left = on_port.gap;
					mode         <= on_port.mode;
					button_a     <= on_port.btn_a;
					button_b     <= on_port.btn_b;
					in_valid     <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Monitor: random stalls, one long hold-off on demand, field checks
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready     <= 1'b0;
			rx_stall_left = 0;
		end else begin
			if (out_valid && out_ready) begin
				checked_total++;
				if (lamp_expect_q.size() == 0) begin
					$display("%0t: result with nothing expected: green_on %0b lamp_set %0b request_pending %0b",
						$time, green_on, lamp_set, request_pending);
					mismatch_count++;
				end else begin
					rx_want = lamp_expect_q.pop_front();
					if (green_on !== rx_want.green) begin
						$display("%0t: green_on expected %0b actual %0b",
							$time, rx_want.green, green_on);
						mismatch_count++;
					end
					if (lamp_set !== rx_want.lamp) begin
						$display("%0t: lamp_set expected %0b actual %0b",
							$time, rx_want.lamp, lamp_set);
						mismatch_count++;
					end
					if (request_pending !== rx_want.pend) begin
						$display("%0t: request_pending expected %0b actual %0b",
							$time, rx_want.pend, request_pending);
						mismatch_count++;
					end
				end
				rx_stall_left = draw_wait();
			end else if (rx_stall_left > 0) begin
				rx_stall_left--;
			end
			// long hold-off so the pipe fills and in_ready drops
			if (rx_hold_start) begin
				rx_stall_left = HOLD_CYCLES;
				rx_hold_start <= 1'b0;
			end
			out_ready <= (rx_stall_left == 0);
		end
	end

	// ---------------------------------------------------------------
	// Watchdog: no handshake of any kind for too long
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog expired, %0d results outstanding",
				$time, sent_total - checked_total);
			$display("FAILED: results differ");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------
	task automatic push_req(logic [MODE_W-1:0] m, logic a, logic b);
		light_req_t r;
		r.mode  = m;
		r.btn_a = a;
		r.btn_b = b;
		r.gap   = draw_wait();
		request_q.push_back(r);
		sent_total++;
	endtask

	// mostly ticks with random buttons, some commands, a little noise
	task automatic push_mixed(int n);
		int pick;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				push_req(MODE_TICK, 1'($urandom), 1'($urandom));
			end else if (pick < 95) begin
				push_req(MODE_W'($urandom_range(MODE_TOGGLE, MODE_RESTART)),
					1'($urandom), 1'($urandom));
			end else begin
				push_req(MODE_W'($urandom_range(MODE_UNUSED_FIRST, MODE_UNUSED_LAST)),
					1'($urandom), 1'($urandom));
			end
		end
	endtask

	// sender holds back until every predicted result is in
	task automatic wait_drained();
		while (checked_total != sent_total) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_AUTO_ENABLE:    ctl_auto   = val[0];
			REG_TOGGLE_ENABLE:  ctl_toggle = val[0];
			REG_REQUEST_ENABLE: ctl_req    = val[0];
			REG_RED_SECONDS:    ctl_red    = val[SECONDS_W-1:0];
			REG_GREEN_SECONDS:  ctl_green  = val[SECONDS_W-1:0];
			REG_DELAY_SECONDS:  ctl_delay  = val[SECONDS_W-1:0];
			default: ;
		endcase
	endtask

	task automatic write_settings(logic auto_on, logic toggle_on, logic req_on,
		logic [SECONDS_W-1:0] red_s, logic [SECONDS_W-1:0] green_s,
		logic [SECONDS_W-1:0] delay_s);
		set_reg(REG_AUTO_ENABLE,    CFG_DATA_W'(auto_on));
		set_reg(REG_TOGGLE_ENABLE,  CFG_DATA_W'(toggle_on));
		set_reg(REG_REQUEST_ENABLE, CFG_DATA_W'(req_on));
		set_reg(REG_RED_SECONDS,    CFG_DATA_W'(red_s));
		set_reg(REG_GREEN_SECONDS,  CFG_DATA_W'(green_s));
		set_reg(REG_DELAY_SECONDS,  CFG_DATA_W'(delay_s));
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, reset settings: every mode with nothing enabled.
		// Buttons toggle here but no feature is on yet.
		push_req(MODE_TICK, 1'b0, 1'b0);
		push_req(MODE_TICK, 1'b1, 1'b0);
		push_req(MODE_TICK, 1'b1, 1'b1);
		push_req(MODE_TICK, 1'b0, 1'b1);
		push_req(MODE_TICK, 1'b0, 1'b0);
		// commands carry button levels that must be ignored
		push_req(MODE_TOGGLE, 1'b1, 1'b1);
		push_req(MODE_FORCE_RED, 1'b0, 1'b1);
		push_req(MODE_FORCE_GREEN, 1'b1, 1'b0);
		push_req(MODE_RESTART, 1'b1, 1'b1);
		// unused modes: no state change, no lamp drive
		push_req(MODE_UNUSED_FIRST, 1'b1, 1'b1);
		push_req(MODE_W'(MODE_UNUSED_FIRST + 1), 1'b0, 1'b0);
		push_req(MODE_UNUSED_LAST, 1'b1, 1'b0);
		wait_drained();

		// Everything on, zero-length timers: a timer armed on a tick fires there
		write_settings(1'b1, 1'b1, 1'b1, 12'd0, 12'd0, 12'd0);
		push_req(MODE_RESTART, 1'b0, 1'b0);
		push_req(MODE_TICK, 1'b0, 1'b0);
		push_req(MODE_TICK, 1'b0, 1'b0);
		push_req(MODE_TICK, 1'b1, 1'b0); // press toggles, then the timer fires too
		push_req(MODE_TOGGLE, 1'b0, 1'b0);
		push_req(MODE_FORCE_GREEN, 1'b0, 1'b0);
		push_req(MODE_FORCE_RED, 1'b0, 1'b0);
		push_req(MODE_TICK, 1'b0, 1'b1); // level held, no edge
		wait_drained();

		// Hour-long timers, request only: press while red arms the request,
		// toggle from red cancels it and starts the green phase
		write_settings(1'b0, 1'b0, 1'b1, 12'd3600, 12'd3600, 12'd3600);
		push_req(MODE_RESTART, 1'b0, 1'b0);
		push_req(MODE_TICK, 1'b0, 1'b0);
		push_req(MODE_TICK, 1'b1, 1'b1);
		push_req(MODE_TOGGLE, 1'b0, 1'b0);
		push_req(MODE_UNUSED_LAST, 1'b0, 1'b0);
		wait_drained();

		// Random: auto with all three times zero; any timer armed from here fires on the tick that sees it
		write_settings(1'b1, 1'b1, 1'b1, 12'd0, 12'd0, 12'd0);
		push_mixed(20);
		wait_drained();

		// Random: manual toggle with random lengths, no idling on either side
		no_idle = 1'b1;
		write_settings(1'b0, 1'b1, 1'b1, 12'($urandom_range(0, 3600)),
			12'($urandom_range(0, 3600)), 12'd0);
		push_mixed(20);
		wait_drained();
		no_idle = 1'b0;

		// Random: auto, long red, instant requests; receiver holds off
		// while the sender keeps offering, so the input side stalls
		write_settings(1'b1, 1'b0, 1'b1, 12'd3600, 12'd0, 12'd0);
		push_mixed(40);
		@(posedge clk);
		rx_hold_start <= 1'b1;
		wait_drained();

		// Random: request only, auto off; green times out to red and stops
		write_settings(1'b0, 1'b0, 1'b1, 12'd0, 12'd0, 12'd0);
		push_mixed(20);
		wait_drained();

		// One full 1 s red phase counted down tick by tick in auto mode
		write_settings(1'b1, 1'b0, 1'b0, 12'd1, 12'd0, 12'd1);
		push_req(MODE_RESTART, 1'b0, 1'b0);
		for (int i = 0; i < LONG_TICKS; i++) push_req(MODE_TICK, 1'b0, 1'b0);
		push_mixed(20);
		wait_drained();

		mismatch_count += lamp_expect_q.size();
		if (mismatch_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

/* files.f */
rtl/core/rtlc_pkg.sv
rtl/core/rtlc_cfg.sv
rtl/core/rtlc_step.sv
rtl/core/request_traffic_light_controller_core.sv
rtl/core/rtlc_checker.sv
bench/testbench.sv
